[rtl/mwr_pkg.sv]
// ----------------------------------------------------------------------------
// mwr_pkg
// Types and constants shared by the microwire eeprom read master files.
// ----------------------------------------------------------------------------
package mwr_pkg;

    localparam int unsigned PADDR_W     = 3;
    localparam int unsigned PDATA_W     = 32;
    localparam int unsigned ADDR_W      = 8;
    localparam int unsigned DATA_W      = 16;
    localparam int unsigned CMD_W       = 11;
    localparam int unsigned CNT_W       = 5;
    localparam int unsigned WAIT_W      = 8;
    localparam int unsigned OPCODE_W    = 3;
    localparam int unsigned ADDR_SMALL  = 6;
    localparam int unsigned ADDR_LARGE  = 8;

    localparam logic [WAIT_W-1:0] GRANT_TIMEOUT_RST = 8'd100;

    // register index, taken from paddr[2]
    typedef enum logic
    {
        REG_LARGE_DEVICE  = 1'b0,
        REG_GRANT_TIMEOUT = 1'b1
    } reg_idx_t;

    // sequencer phases, one-hot
    typedef enum logic [11:0]
    {
        PH_IDLE     = 12'b0000_0000_0001,
        PH_WAIT     = 12'b0000_0000_0010,
        PH_CMD_LOW  = 12'b0000_0000_0100,
        PH_CMD_HIGH = 12'b0000_0000_1000,
        PH_CMD_END  = 12'b0000_0001_0000,
        PH_DAT_HIGH = 12'b0000_0010_0000,
        PH_DAT_LOW  = 12'b0000_0100_0000,
        PH_SB1      = 12'b0000_1000_0000,
        PH_SB2      = 12'b0001_0000_0000,
        PH_SB3      = 12'b0010_0000_0000,
        PH_SB4      = 12'b0100_0000_0000,
        PH_FINISH   = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed
    {
        logic              large_device;
        logic [WAIT_W-1:0] grant_timeout;
    } cfg_t;

    typedef struct packed
    {
        logic rq;
        logic di;
        logic sk;
        logic cs;
    } pins_t;

    typedef struct packed
    {
        logic              start_req;
        logic [ADDR_W-1:0] word_address;
        logic              grant;
        logic              serial_in;
    } req_t;

    typedef struct packed
    {
        logic              chip_select;
        logic              serial_clock;
        logic              serial_out;
        logic              request;
        logic              busy_res;
        logic              done_res;
        logic              failed;
        logic [DATA_W-1:0] read_data;
    } res_t;

endpackage

[rtl/mwr_if.sv]
// ----------------------------------------------------------------------------
// mwr_if
// Tick and result channels of the microwire eeprom read master.
// ----------------------------------------------------------------------------
interface mwr_req_if
    import mwr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              start_req;
    logic [ADDR_W-1:0] word_address;
    logic              grant;
    logic              serial_in;

    modport source (output valid, start_req, word_address, grant, serial_in, input ready);
    modport sink   (input valid, start_req, word_address, grant, serial_in, output ready);
endinterface

interface mwr_res_if
    import mwr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              chip_select;
    logic              serial_clock;
    logic              serial_out;
    logic              request;
    logic              busy_res;
    logic              done_res;
    logic              failed;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, chip_select, serial_clock, serial_out, request, busy_res,
                    done_res, failed, read_data, input ready);
    modport sink   (input valid, chip_select, serial_clock, serial_out, request, busy_res,
                    done_res, failed, read_data, output ready);
endinterface

[rtl/microwire_eeprom_read_master.sv]
// ----------------------------------------------------------------------------
// microwire_eeprom_read_master
// Tick-driven master for a microwire serial eeprom word read.
// ----------------------------------------------------------------------------
// usage
//   req_ch carries one tick per transaction: start_req, word_address, the
//   arbiter grant and the eeprom data out pin. res_ch returns exactly one
//   transaction per tick with the pin levels (chip_select, serial_clock,
//   serial_out), the bus request, busy, a done pulse, the failure flag and
//   the data shift register.
//   a start in idle raises request and waits up to grant_timeout+1 ticks
//   for grant; then the 3-bit read opcode and 6 or 8 address bits go out
//   msb first, 16 data bits are clocked in and the standby pin sequence
//   runs before done. after the grant tick a read takes 2*(3+8+16)+6 = 60
//   more ticks with an 8-bit address (56 with 6), done on the last of them.
//   the result of a tick is registered in the output register on the edge
//   that accepts it. throughput: one tick per cycle unless res_ch stalls;
//   the sequencer state and the output register update on the same edge.
//   stall: req_ch.ready follows res_ch.ready while a result is held, so
//   a stalled receiver freezes the sequence; nothing is lost or repeated.
//   reset: the sequencer returns to idle with all pins low, no result is
//   pending, large_device clears and grant_timeout reloads to 100.
//   config writes through the apb port are only expected while idle.
// ----------------------------------------------------------------------------
module microwire_eeprom_read_master
    import mwr_pkg::*;
#(
    parameter int unsigned READ_OPCODE = 6,
    parameter int unsigned DATA_BITS   = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    mwr_req_if.sink            req_ch,
    mwr_res_if.source          res_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t cfg;
    req_t req;
    res_t res_next;
    res_t res_reg;
    logic res_valid_reg;
    logic accept;

    // configuration registers
    mwr_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // tick payload gathered into one struct
    assign req.start_req    = req_ch.start_req;
    assign req.word_address = req_ch.word_address;
    assign req.grant        = req_ch.grant;
    assign req.serial_in    = req_ch.serial_in;

    // take a tick whenever the output register is empty or being drained
    assign req_ch.ready = !res_valid_reg || res_ch.ready;
    assign accept       = req_ch.valid && req_ch.ready;

    // sequencer state advances only on an accepted tick
    mwr_seq #(
        .READ_OPCODE (READ_OPCODE),
        .DATA_BITS   (DATA_BITS)
    ) u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (accept),
        .req   (req),
        .cfg   (cfg),
        .res   (res_next)
    );

    // output register, one result transaction per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ch.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_ch.valid        = res_valid_reg;
    assign res_ch.chip_select  = res_reg.chip_select;
    assign res_ch.serial_clock = res_reg.serial_clock;
    assign res_ch.serial_out   = res_reg.serial_out;
    assign res_ch.request      = res_reg.request;
    assign res_ch.busy_res     = res_reg.busy_res;
    assign res_ch.done_res     = res_reg.done_res;
    assign res_ch.failed       = res_reg.failed;
    assign res_ch.read_data    = res_reg.read_data;

endmodule

[rtl/mwr_regs.sv]
// ----------------------------------------------------------------------------
// mwr_regs
// APB configuration registers: device size and grant timeout.
// ----------------------------------------------------------------------------
module mwr_regs
    import mwr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.large_device  <= 1'b0;
            cfg_reg.grant_timeout <= GRANT_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_LARGE_DEVICE:  cfg_reg.large_device  <= pwdata[0];
                REG_GRANT_TIMEOUT: cfg_reg.grant_timeout <= pwdata[WAIT_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_LARGE_DEVICE:  prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.large_device};
            REG_GRANT_TIMEOUT: prdata = {{(PDATA_W-WAIT_W){1'b0}}, cfg_reg.grant_timeout};
            default:           prdata = '0;
        endcase
    end

endmodule

[rtl/mwr_seq.sv]
// ----------------------------------------------------------------------------
// mwr_seq
// Pin sequencer: advances one edge of the read sequence per accepted tick.
// ----------------------------------------------------------------------------
module mwr_seq
    import mwr_pkg::*;
#(
    parameter int unsigned READ_OPCODE = 6,
    parameter int unsigned DATA_BITS   = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  req_t req,
    input  cfg_t cfg,
    output res_t res
);

    localparam logic [OPCODE_W-1:0] OPC      = OPCODE_W'(READ_OPCODE);
    localparam logic [CNT_W-1:0]    DATA_CNT = CNT_W'(DATA_BITS % 32);

    phase_t              phase_reg, phase_next;
    logic [CNT_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [CMD_W-1:0]    cmd_shift_reg, cmd_shift_next;
    logic [DATA_W-1:0]   data_shift_reg, data_shift_next;
    logic [WAIT_W-1:0]   wait_cnt_reg, wait_cnt_next;
    pins_t               pins_reg, pins_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;

    logic [CNT_W-2:0]    bit_pos;
    logic [CMD_W-1:0]    cmd_window;
    logic                cmd_bit;
    logic [CNT_W-1:0]    bit_cnt_dec;
    logic                busy, done, fail;

    // command bit under the counter, msb first
    assign bit_pos     = bit_cnt_reg[CNT_W-2:0] - 1'b1;
    assign cmd_window  = cmd_shift_reg >> bit_pos;
    assign cmd_bit     = cmd_window[0];
    assign bit_cnt_dec = bit_cnt_reg - 1'b1;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        cmd_shift_next  = cmd_shift_reg;
        data_shift_next = data_shift_reg;
        wait_cnt_next   = wait_cnt_reg;
        pins_next       = pins_reg;
        addr_next       = addr_reg;
        busy            = 1'b1;
        done            = 1'b0;
        fail            = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (req.start_req)
                begin
                    addr_next     = req.word_address;
                    wait_cnt_next = '0;
                    pins_next.rq  = 1'b1;
                    phase_next    = PH_WAIT;
                end
                else
                begin
                    busy = 1'b0;
                end
            end
            PH_WAIT:
            begin
                if (req.grant)
                begin
                    if (cfg.large_device)
                    begin
                        cmd_shift_next = {OPC, addr_reg};
                        bit_cnt_next   = CNT_W'(OPCODE_W + ADDR_LARGE);
                    end
                    else
                    begin
                        cmd_shift_next = {2'b00, OPC, addr_reg[ADDR_SMALL-1:0]};
                        bit_cnt_next   = CNT_W'(OPCODE_W + ADDR_SMALL);
                    end
                    pins_next.cs = 1'b1;
                    pins_next.sk = 1'b0;
                    pins_next.di = 1'b0;
                    phase_next   = PH_CMD_LOW;
                end
                else if (wait_cnt_reg >= cfg.grant_timeout)
                begin
                    pins_next.rq = 1'b0;
                    busy         = 1'b0;
                    done         = 1'b1;
                    fail         = 1'b1;
                    phase_next   = PH_IDLE;
                end
                else
                begin
                    wait_cnt_next = wait_cnt_reg + 1'b1;
                end
            end
            PH_CMD_LOW:
            begin
                pins_next.cs = 1'b1;
                pins_next.sk = 1'b0;
                pins_next.di = cmd_bit;
                phase_next   = PH_CMD_HIGH;
            end
            PH_CMD_HIGH:
            begin
                pins_next.cs = 1'b1;
                pins_next.sk = 1'b1;
                pins_next.di = cmd_bit;
                bit_cnt_next = bit_cnt_dec;
                phase_next   = (bit_cnt_dec != '0) ? PH_CMD_LOW : PH_CMD_END;
            end
            PH_CMD_END:
            begin
                pins_next.cs    = 1'b1;
                pins_next.sk    = 1'b0;
                pins_next.di    = 1'b0;
                data_shift_next = '0;
                bit_cnt_next    = DATA_CNT;
                phase_next      = (DATA_CNT != '0) ? PH_DAT_HIGH : PH_SB1;
            end
            PH_DAT_HIGH:
            begin
                pins_next.cs = 1'b1;
                pins_next.sk = 1'b1;
                pins_next.di = 1'b0;
                phase_next   = PH_DAT_LOW;
            end
            PH_DAT_LOW:
            begin
                pins_next.cs    = 1'b1;
                pins_next.sk    = 1'b0;
                pins_next.di    = 1'b0;
                data_shift_next = {data_shift_reg[DATA_W-2:0], req.serial_in};
                bit_cnt_next    = bit_cnt_dec;
                phase_next      = (bit_cnt_dec != '0) ? PH_DAT_HIGH : PH_SB1;
            end
            PH_SB1:
            begin
                pins_next.cs = 1'b0;
                pins_next.sk = 1'b0;
                pins_next.di = 1'b0;
                phase_next   = PH_SB2;
            end
            PH_SB2:
            begin
                pins_next.cs = 1'b0;
                pins_next.sk = 1'b1;
                pins_next.di = 1'b0;
                phase_next   = PH_SB3;
            end
            PH_SB3:
            begin
                pins_next.cs = 1'b1;
                pins_next.sk = 1'b1;
                pins_next.di = 1'b0;
                phase_next   = PH_SB4;
            end
            PH_SB4:
            begin
                pins_next.cs = 1'b1;
                pins_next.sk = 1'b0;
                pins_next.di = 1'b0;
                phase_next   = PH_FINISH;
            end
            default:
            begin
                pins_next.rq = 1'b0;
                busy         = 1'b0;
                done         = 1'b1;
                phase_next   = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_cnt_reg    <= '0;
            cmd_shift_reg  <= '0;
            data_shift_reg <= '0;
            wait_cnt_reg   <= '0;
            pins_reg       <= '0;
            addr_reg       <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bit_cnt_reg    <= bit_cnt_next;
            cmd_shift_reg  <= cmd_shift_next;
            data_shift_reg <= data_shift_next;
            wait_cnt_reg   <= wait_cnt_next;
            pins_reg       <= pins_next;
            addr_reg       <= addr_next;
        end
    end

    always_comb
    begin
        res.chip_select  = pins_next.cs;
        res.serial_clock = pins_next.sk;
        res.serial_out   = pins_next.di;
        res.request      = pins_next.rq;
        res.busy_res     = busy;
        res.done_res     = done;
        res.failed       = fail;
        res.read_data    = data_shift_next;
    end

endmodule

[rtl/mwr_checker.sv]
// ----------------------------------------------------------------------------
// mwr_checker
// Port-level checks for the microwire eeprom read master.
// ----------------------------------------------------------------------------
module mwr_checker
    import mwr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mwr_req_if.sink   req_ch,
    mwr_res_if.source res_ch
);

    // a held result blocks new ticks
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && !res_ch.ready) |-> !req_ch.ready)
        else $error("tick accepted while result stalled");

    // failure only with done
    a_fail_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && res_ch.failed) |-> res_ch.done_res)
        else $error("failed without done");

    // done ends the sequence: request and busy are down
    a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && res_ch.done_res) |-> (!res_ch.request && !res_ch.busy_res))
        else $error("done with request or busy still set");

    // a good read leaves the pins in standby
    a_standby_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && res_ch.done_res && !res_ch.failed)
            |-> (res_ch.chip_select && !res_ch.serial_clock && !res_ch.serial_out))
        else $error("pins not in standby at end of read");

    // stalled result holds
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && !res_ch.ready) |=> (res_ch.valid && $stable(res_ch.read_data)))
        else $error("stalled result changed");

endmodule

bind microwire_eeprom_read_master mwr_checker u_mwr_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .req_ch (req_ch),
    .res_ch (res_ch)
);

[tb/microwire_eeprom_read_master_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// microwire_eeprom_read_master_tb
// Self-checking bench for the microwire eeprom word-read master. A short
// table of directed ticks comes first, then random read sequences under
// several register settings. Every tick result is compared field by field
// against a typed value or the bench's cycle model of the pin sequencer.
// ----------------------------------------------------------------------------
module microwire_eeprom_read_master_tb;
    import mwr_pkg::*;

    localparam int unsigned CLK_PERIOD   = 10;
    localparam int unsigned RD_OPCODE    = 6;
    localparam int unsigned RX_BITS      = 16;
    // worst run is roughly 1100 ticks, so this limit is loose
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned TICKS_PER_SETTING = 110;
    localparam int unsigned SETTINGS_CNT = 5;
    localparam int unsigned PLAN_ROWS    = 24;

    // typed-in results for rows whose outcome is obvious
    // field order: cs, sk, di, rq, busy, done, failed, read_data
    localparam res_t RES_QUIET     = '0;
    localparam res_t RES_REQUEST   = {1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000};
    localparam res_t RES_TIMED_OUT = {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 16'h0000};
    localparam res_t RES_GRANTED   = {1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000};

    typedef enum logic
    {
        ROW_TICK = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_t;

    typedef struct
    {
        row_kind_t          kind;
        reg_idx_t           idx;
        logic [PDATA_W-1:0] value;
        req_t               tick;
        logic               typed;
        res_t               want;
    } plan_row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    mwr_req_if req_ch ();
    mwr_res_if res_ch ();

    microwire_eeprom_read_master #(
        .READ_OPCODE (RD_OPCODE),
        .DATA_BITS   (RX_BITS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_ch  (req_ch),
        .res_ch  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // sequencer model state, mirrors the block after reset
    // ------------------------------------------------------------------
    logic                cfg_large   = 1'b0;
    logic [WAIT_W-1:0]   cfg_timeout = GRANT_TIMEOUT_RST;
    phase_t              seq_phase   = PH_IDLE;
    logic [CNT_W-1:0]    bits_left   = '0;
    logic [CMD_W-1:0]    cmd_word    = '0;
    logic [DATA_W-1:0]   rx_word     = '0;
    logic [WAIT_W-1:0]   grant_polls = '0;
    pins_t               pin_state   = '0;
    logic [ADDR_W-1:0]   target_word = '0;

    // expected tick results in acceptance order
    res_t        pin_forecast [$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    // typed expectation travelling with the tick on the channel
    logic        typed_pending = 1'b0;
    res_t        typed_value   = '0;

    // sender-side plan for the grant line of the current read
    int unsigned polls_seen  = 0;
    int unsigned grant_after = 0;
    logic        sender_calm = 1'b0;

    // register settings walked by the random part
    logic              setting_large   [SETTINGS_CNT] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    logic [WAIT_W-1:0] setting_timeout [SETTINGS_CNT] = '{8'd3, 8'd255, 8'd0, 8'd12, 8'd1};

    // directed table: after reset, zero timeout failure, start while busy,
    // grant on the last sample, then the opening command bits of a large
    // device read with grant dropped and start raised mid-read
    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b0, 8'hFF, 1'b1, 1'b1}, 1'b1, RES_QUIET},
        '{ROW_CFG,  REG_GRANT_TIMEOUT, 32'd0, '0,                        1'b0, '0},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b1, 8'h00, 1'b0, 1'b0}, 1'b1, RES_REQUEST},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b1, 8'hFF, 1'b0, 1'b1}, 1'b1, RES_TIMED_OUT},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b0, 8'h00, 1'b0, 1'b0}, 1'b1, RES_QUIET},
        '{ROW_CFG,  REG_LARGE_DEVICE,  32'd1, '0,                        1'b0, '0},
        '{ROW_CFG,  REG_GRANT_TIMEOUT, 32'd1, '0,                        1'b0, '0},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b1, 8'hFF, 1'b1, 1'b0}, 1'b1, RES_REQUEST},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b1, 8'h00, 1'b0, 1'b1}, 1'b1, RES_REQUEST},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b0, 8'h55, 1'b1, 1'b0}, 1'b1, RES_GRANTED},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b1, 8'hAA, 1'b0, 1'b1}, 1'b0, '0},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b0, 8'h00, 1'b1, 1'b0}, 1'b0, '0},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b1, 8'hFF, 1'b0, 1'b1}, 1'b0, '0},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b0, 8'h0F, 1'b1, 1'b1}, 1'b0, '0},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b1, 8'hF0, 1'b0, 1'b0}, 1'b0, '0},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b0, 8'h33, 1'b1, 1'b1}, 1'b0, '0},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b1, 8'hCC, 1'b0, 1'b0}, 1'b0, '0},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b0, 8'h80, 1'b1, 1'b1}, 1'b0, '0},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b1, 8'h01, 1'b0, 1'b0}, 1'b0, '0},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b0, 8'h7F, 1'b1, 1'b1}, 1'b0, '0},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b1, 8'hFE, 1'b0, 1'b0}, 1'b0, '0},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b0, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b1, 8'hFF, 1'b0, 1'b0}, 1'b0, '0},
        '{ROW_TICK, REG_LARGE_DEVICE,  32'd0, {1'b0, 8'h5A, 1'b1, 1'b1}, 1'b0, '0}
    };

    // ------------------------------------------------------------------
    // clock and cycle watchdog
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequencer model: one tick in, the pin levels and flags of that tick out
    // ------------------------------------------------------------------
    task automatic predict_eeprom_tick(input req_t t, output res_t out);
        logic [2:0] lines;      // {di, sk, cs}
        logic       req_line;
        logic       busy;
        logic       done;
        logic       fail;
        lines    = {pin_state.di, pin_state.sk, pin_state.cs};
        req_line = pin_state.rq;
        busy     = 1'b1;
        done     = 1'b0;
        fail     = 1'b0;
        case (seq_phase)
            PH_IDLE:
            begin
                if (t.start_req)
                begin
                    target_word = t.word_address;
                    grant_polls = '0;
                    req_line    = 1'b1;
                    seq_phase   = PH_WAIT;
                end
                else
                begin
                    busy = 1'b0;
                end
            end
            PH_WAIT:
            begin
                if (t.grant)
                begin
                    // opcode and address packed msb first, sent from the top bit down
                    if (cfg_large)
                    begin
                        cmd_word  = {3'(RD_OPCODE), target_word};
                        bits_left = CNT_W'(OPCODE_W + ADDR_LARGE);
                    end
                    else
                    begin
                        cmd_word  = {2'b00, 3'(RD_OPCODE), target_word[ADDR_SMALL-1:0]};
                        bits_left = CNT_W'(OPCODE_W + ADDR_SMALL);
                    end
                    lines     = 3'b001;
                    seq_phase = PH_CMD_LOW;
                end
                else if (grant_polls >= cfg_timeout)
                begin
                    // no grant in time: request drops, other pins hold
                    req_line  = 1'b0;
                    busy      = 1'b0;
                    done      = 1'b1;
                    fail      = 1'b1;
                    seq_phase = PH_IDLE;
                end
                else
                begin
                    grant_polls = grant_polls + 1'b1;
                end
            end
            PH_CMD_LOW:
            begin
                lines     = {cmd_word[bits_left - 1'b1], 2'b01};
                seq_phase = PH_CMD_HIGH;
            end
            PH_CMD_HIGH:
            begin
                lines     = {cmd_word[bits_left - 1'b1], 2'b11};
                bits_left = bits_left - 1'b1;
                seq_phase = (bits_left != 0) ? PH_CMD_LOW : PH_CMD_END;
            end
            PH_CMD_END:
            begin
                lines     = 3'b001;
                rx_word   = '0;
                bits_left = CNT_W'(RX_BITS);
                seq_phase = (bits_left != 0) ? PH_DAT_HIGH : PH_SB1;
            end
            PH_DAT_HIGH:
            begin
                lines     = 3'b011;
                seq_phase = PH_DAT_LOW;
            end
            PH_DAT_LOW:
            begin
                // data out is taken on the clock-low tick after each high tick
                lines     = 3'b001;
                rx_word   = {rx_word[DATA_W-2:0], t.serial_in};
                bits_left = bits_left - 1'b1;
                seq_phase = (bits_left != 0) ? PH_DAT_HIGH : PH_SB1;
            end
            // standby: cs and sk low, sk high, cs high, sk low
            PH_SB1:
            begin
                lines     = 3'b000;
                seq_phase = PH_SB2;
            end
            PH_SB2:
            begin
                lines     = 3'b010;
                seq_phase = PH_SB3;
            end
            PH_SB3:
            begin
                lines     = 3'b011;
                seq_phase = PH_SB4;
            end
            PH_SB4:
            begin
                lines     = 3'b001;
                seq_phase = PH_FINISH;
            end
            default:
            begin
                req_line  = 1'b0;
                busy      = 1'b0;
                done      = 1'b1;
                seq_phase = PH_IDLE;
            end
        endcase
        pin_state = {req_line, lines};
        out = {pin_state.cs, pin_state.sk, pin_state.di, pin_state.rq,
               busy, done, fail, rx_word};
    endtask

    function automatic void match_field(input string what, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // monitor: predict on each accepted tick, check each accepted result
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        req_t tick;
        res_t model_out;
        res_t want;
        // prediction first so the check never depends on event order
        if (req_ch.valid && req_ch.ready)
        begin
            tick = {req_ch.start_req, req_ch.word_address, req_ch.grant, req_ch.serial_in};
            predict_eeprom_tick(tick, model_out);
            pin_forecast.push_back(typed_pending ? typed_value : model_out);
        end
        if (res_ch.valid && res_ch.ready)
        begin
            if (pin_forecast.size() == 0)
            begin
                $display("%0t: result transaction with nothing expected", $time);
                mismatches++;
            end
            else
            begin
                want = pin_forecast.pop_front();
                match_field("chip_select",  DATA_W'(want.chip_select),  DATA_W'(res_ch.chip_select));
                match_field("serial_clock", DATA_W'(want.serial_clock), DATA_W'(res_ch.serial_clock));
                match_field("serial_out",   DATA_W'(want.serial_out),   DATA_W'(res_ch.serial_out));
                match_field("request",      DATA_W'(want.request),      DATA_W'(res_ch.request));
                match_field("busy_res",     DATA_W'(want.busy_res),     DATA_W'(res_ch.busy_res));
                match_field("done_res",     DATA_W'(want.done_res),     DATA_W'(res_ch.done_res));
                match_field("failed",       DATA_W'(want.failed),       DATA_W'(res_ch.failed));
                match_field("read_data",    want.read_data,             res_ch.read_data);
            end
        end
    end

    // mostly no pause, often a short one, now and then a long one
    function automatic int unsigned pick_pause();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // driver tasks: each one is entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic send_tick(input req_t t, input logic typed, input res_t want);
        int unsigned gap;
        gap = sender_calm ? 0 : pick_pause();
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.start_req    <= t.start_req;
        req_ch.word_address <= t.word_address;
        req_ch.grant        <= t.grant;
        req_ch.serial_in    <= t.serial_in;
        typed_pending       <= typed;
        typed_value         <= want;
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
        @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        // setup cycle
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        // access cycle, register lands on the edge with pready high
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_LARGE_DEVICE)
            cfg_large = value[0];
        else
            cfg_timeout = value[WAIT_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // run the current read out with grant held, then let every result drain
    task automatic settle_idle();
        req_t t;
        while (seq_phase != PH_IDLE)
        begin
            t = {1'b0, 8'($urandom), 1'b1, 1'($urandom)};
            send_tick(t, 1'b0, '0);
        end
        req_ch.valid <= 1'b0;
        while (pin_forecast.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // random tick shaped by the modeled phase: mostly complete reads with
    // random addresses and data, grant early, on the last sample or never
    function automatic req_t next_tick();
        req_t        t;
        int unsigned roll;
        t.start_req    = 1'($urandom);
        t.word_address = 8'($urandom);
        t.grant        = 1'($urandom);
        t.serial_in    = 1'($urandom);
        if (seq_phase == PH_IDLE)
        begin
            t.start_req = ($urandom_range(0, 3) != 0);
            if (t.start_req)
            begin
                polls_seen  = 0;
                sender_calm = ($urandom_range(0, 4) == 0);
                roll = $urandom_range(0, 9);
                if (roll < 5)
                    grant_after = $urandom_range(0, 3);
                else if (roll < 7)
                    grant_after = cfg_timeout;              // last sample still wins
                else if (roll < 9)
                    grant_after = cfg_timeout + 1;          // timeout
                else
                    grant_after = $urandom_range(0, cfg_timeout + 1);
            end
        end
        else if (seq_phase == PH_WAIT)
        begin
            t.grant = (polls_seen == grant_after);
            // occasional glitch on the grant line
            if ($urandom_range(0, 19) == 0)
                t.grant = ~t.grant;
            polls_seen++;
        end
        return t;
    endfunction

    // ------------------------------------------------------------------
    // receiver: random stalls with occasional stretches of none
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned hold;
        int unsigned steady;
        res_ch.ready = 1'b0;
        steady       = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (steady == 0 && $urandom_range(0, 199) == 0)
                steady = $urandom_range(40, 200);
            hold = (steady != 0) ? 0 : pick_pause();
            if (steady != 0)
                steady--;
            if (hold == 0)
            begin
                res_ch.ready <= 1'b1;
            end
            else
            begin
                res_ch.ready <= 1'b0;
                repeat (hold - 1) @(negedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_ch.valid        = 1'b0;
        req_ch.start_req    = 1'b0;
        req_ch.word_address = '0;
        req_ch.grant        = 1'b0;
        req_ch.serial_in    = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table; register rows wait for the sequencer to go idle
        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle_idle();
                write_reg(plan[i].idx, plan[i].value);
            end
            else
            begin
                send_tick(plan[i].tick, plan[i].typed, plan[i].want);
            end
        end

        // random reads under each register setting
        for (int s = 0; s < SETTINGS_CNT; s++)
        begin
            settle_idle();
            write_reg(REG_LARGE_DEVICE, PDATA_W'(setting_large[s]));
            write_reg(REG_GRANT_TIMEOUT, PDATA_W'(setting_timeout[s]));
            repeat (TICKS_PER_SETTING)
                send_tick(next_tick(), 1'b0, '0);
        end

        settle_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pin_forecast.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
